// File: src/two_plane_track_angle_macros.svh
// ----------------------------------------------------------------------------
// two plane track angle assertion macros
// shared property shorthands for the track angle block
// ----------------------------------------------------------------------------
`ifndef TWO_PLANE_TRACK_ANGLE_MACROS_SVH
`define TWO_PLANE_TRACK_ANGLE_MACROS_SVH

// same-cycle implication
`define TPTA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TPTA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/tpta_pkg.sv
// ----------------------------------------------------------------------------
// tpta_pkg
// widths, codes and tables shared by the track angle pipeline
// ----------------------------------------------------------------------------
package tpta_pkg;

   localparam int CORDIC_STAGES_DEF = 16;
   localparam int CORDIC_MAX        = 24;

   localparam int COORD_W   = 15;
   localparam int OUT_W     = 16;
   localparam int SPACING_W = 15;
   localparam int GAP_W     = 12;
   localparam int CSR_DATA_W = 15;

   localparam logic [SPACING_W-1:0] SPACING_RST = 15'd3200;
   localparam logic [GAP_W-1:0]     GAP_RST     = 12'd205;

   // interpolation divider: 32 bit dividend, divisor 2*spacing
   localparam int DIVX_NUM_W = 32;
   localparam int DIVX_REM_W = 16;
   // cosine divider: quotient bits 30..0, divisor up to 33 bits
   localparam int DIVC_NUM_W = 31;
   localparam int DIVC_REM_W = 33;
   // integer square root of the cosine quotient
   localparam int SQRT_VAL_W = 32;
   localparam int SQRT_ROOT_W = SQRT_VAL_W / 2;

   localparam int CORE_STAGES = DIVC_NUM_W + SQRT_ROOT_W;
   localparam int DIVX_PAD    = CORE_STAGES - DIVX_NUM_W;

   // cordic datapath
   localparam int CX_W = 35;
   localparam int CZ_W = 25;
   localparam logic signed [CZ_W-1:0] Z_HALF_PI = 25'sd4194304;
   localparam logic signed [16:0]     Y_SCALE   = 17'sd46341;

   typedef enum logic [0:0] {
      REG_PLANE_SPACING = 1'b0,
      REG_CATHODE_GAP   = 1'b1
   } csr_index_type;

   // atan(2^-i) in units of pi/2^23
   function automatic logic signed [CZ_W-1:0] atan_entry(input int unsigned idx);
      logic signed [CZ_W-1:0] v;
      case (idx)
         0:  v = 25'sd2097152;
         1:  v = 25'sd1238021;
         2:  v = 25'sd654136;
         3:  v = 25'sd332050;
         4:  v = 25'sd166669;
         5:  v = 25'sd83416;
         6:  v = 25'sd41718;
         7:  v = 25'sd20860;
         8:  v = 25'sd10430;
         9:  v = 25'sd5215;
         10: v = 25'sd2608;
         11: v = 25'sd1304;
         12: v = 25'sd652;
         13: v = 25'sd326;
         14: v = 25'sd163;
         15: v = 25'sd81;
         16: v = 25'sd41;
         17: v = 25'sd20;
         18: v = 25'sd10;
         19: v = 25'sd5;
         20: v = 25'sd3;
         21: v = 25'sd1;
         22: v = 25'sd1;
         default: v = 25'sd0;
      endcase
      return v;
   endfunction

endpackage

// File: src/tpta_div_cell.sv
// ----------------------------------------------------------------------------
// tpta_div_cell
// one restoring division step, registered, handing state to the next cell
// ----------------------------------------------------------------------------
module tpta_div_cell #(
   parameter int REM_W = 16,
   parameter int NUM_W = 32
) (
   input  logic             clock,
   input  logic [REM_W-1:0] rem_i,
   input  logic [NUM_W-1:0] num_i,
   input  logic [NUM_W-1:0] quo_i,
   input  logic [REM_W-1:0] div_i,
   output logic [REM_W-1:0] rem_o,
   output logic [NUM_W-1:0] num_o,
   output logic [NUM_W-1:0] quo_o,
   output logic [REM_W-1:0] div_o
);

   logic [REM_W:0]   rem2;
   logic [REM_W:0]   diff;
   logic             ge;
   logic [REM_W-1:0] rem_in, rem_ff;
   logic [NUM_W-1:0] num_in, num_ff;
   logic [NUM_W-1:0] quo_in, quo_ff;
   logic [REM_W-1:0] div_ff;

   always_comb begin
      rem2   = {rem_i, num_i[NUM_W-1]};
      diff   = rem2 - {1'b0, div_i};
      ge     = (rem2 >= {1'b0, div_i});
      rem_in = ge ? diff[REM_W-1:0] : rem2[REM_W-1:0];
      num_in = {num_i[NUM_W-2:0], 1'b0};
      quo_in = {quo_i[NUM_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      div_ff <= div_i;
   end

   assign rem_o = rem_ff;
   assign num_o = num_ff;
   assign quo_o = quo_ff;
   assign div_o = div_ff;

endmodule

// File: src/tpta_sqrt_cell.sv
// ----------------------------------------------------------------------------
// tpta_sqrt_cell
// one digit of a bitwise integer square root, registered
// ----------------------------------------------------------------------------
module tpta_sqrt_cell #(
   parameter int VAL_W = 32
) (
   input  logic                   clock,
   input  logic [VAL_W-1:0]       val_i,
   input  logic [VAL_W/2+1:0]     rem_i,
   input  logic [VAL_W/2-1:0]     root_i,
   output logic [VAL_W-1:0]       val_o,
   output logic [VAL_W/2+1:0]     rem_o,
   output logic [VAL_W/2-1:0]     root_o
);

   localparam int ROOT_W = VAL_W / 2;
   localparam int REM_W  = ROOT_W + 2;

   logic [REM_W+1:0]  rem4;
   logic [REM_W+1:0]  trial;
   logic [REM_W+1:0]  diff;
   logic              ge;
   logic [VAL_W-1:0]  val_in, val_ff;
   logic [REM_W-1:0]  rem_in, rem_ff;
   logic [ROOT_W-1:0] root_in, root_ff;

   always_comb begin
      rem4    = {rem_i, val_i[VAL_W-1:VAL_W-2]};
      trial   = {2'b00, root_i, 2'b01};
      diff    = rem4 - trial;
      ge      = (rem4 >= trial);
      rem_in  = ge ? diff[REM_W-1:0] : rem4[REM_W-1:0];
      root_in = {root_i[ROOT_W-2:0], ge};
      val_in  = {val_i[VAL_W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign val_o  = val_ff;
   assign rem_o  = rem_ff;
   assign root_o = root_ff;

endmodule

// File: src/tpta_cordic_cell.sv
// ----------------------------------------------------------------------------
// tpta_cordic_cell
// one vectoring micro-rotation with a fixed shift and angle
// ----------------------------------------------------------------------------
module tpta_cordic_cell #(
   parameter int IDX = 0
) (
   input  logic                              clock,
   input  logic signed [tpta_pkg::CX_W-1:0]  x_i,
   input  logic signed [tpta_pkg::CX_W-1:0]  y_i,
   input  logic signed [tpta_pkg::CZ_W-1:0]  z_i,
   output logic signed [tpta_pkg::CX_W-1:0]  x_o,
   output logic signed [tpta_pkg::CX_W-1:0]  y_o,
   output logic signed [tpta_pkg::CZ_W-1:0]  z_o
);

   localparam logic signed [tpta_pkg::CZ_W-1:0] ATAN = tpta_pkg::atan_entry(IDX);

   logic signed [tpta_pkg::CX_W-1:0] xs, ys;
   logic signed [tpta_pkg::CX_W-1:0] x_in, x_ff, y_in, y_ff;
   logic signed [tpta_pkg::CZ_W-1:0] z_in, z_ff;

   always_comb begin
      xs = x_i >>> IDX;
      ys = y_i >>> IDX;
      // zero y counts as positive
      if (!y_i[tpta_pkg::CX_W-1]) begin
         x_in = x_i + ys;
         y_in = y_i - xs;
         z_in = z_i + ATAN;
      end else begin
         x_in = x_i - ys;
         y_in = y_i + xs;
         z_in = z_i - ATAN;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign x_o = x_ff;
   assign y_o = y_ff;
   assign z_o = z_ff;

endmodule

// File: src/tpta_delay.sv
// ----------------------------------------------------------------------------
// tpta_delay
// fixed-length register line that aligns side data with the cell chains
// ----------------------------------------------------------------------------
module tpta_delay #(
   parameter int W     = 8,
   parameter int DEPTH = 1
) (
   input  logic         clock,
   input  logic [W-1:0] d_i,
   output logic [W-1:0] q_o
);

   logic [W-1:0] line_ff [DEPTH];

   always_ff @(posedge clock) begin
      line_ff[0] <= d_i;
      for (int k = 1; k < DEPTH; k++) begin
         line_ff[k] <= line_ff[k-1];
      end
   end

   assign q_o = line_ff[DEPTH-1];

endmodule

// File: src/two_plane_track_angle.sv
// ----------------------------------------------------------------------------
// two_plane_track_angle
// hit pair to target point, polar cosine and azimuth, fully pipelined
// ----------------------------------------------------------------------------
// usage
//   input: a hit pair (near_x/y, far_x/y) transfers at a rising edge with
//   start high and busy low; busy is high only for the cycle after reset,
//   so a new pair can be taken on every clock
//   output: rsp_strobe is high for exactly one cycle with the four result
//   ports valid; the receiver cannot stall, results must be taken as shown
//   latency: the strobe cycle starts 50 clocks after the start transfer edge;
//   three prep stages (the first loads at the transfer edge), the 31 cell
//   cosine divider, the 16 cell root chain and the output register;
//   the interpolation divider and the cordic chain are padded to match
//   throughput: one pair per cycle, results leave in order
//   config: csr_we writes plane_spacing (index 0) or cathode_gap (index 1);
//   values are sampled per pair as it enters, write only while idle
//   reset: synchronous, clears the valid chain and reloads the config
//   registers with 3200 and 205; pairs in flight are dropped
// ----------------------------------------------------------------------------
`include "two_plane_track_angle_macros.svh"

module two_plane_track_angle #(
   parameter int CORDIC_STAGES = tpta_pkg::CORDIC_STAGES_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic signed [tpta_pkg::COORD_W-1:0]    req_near_x,
   input  logic signed [tpta_pkg::COORD_W-1:0]    req_near_y,
   input  logic signed [tpta_pkg::COORD_W-1:0]    req_far_x,
   input  logic signed [tpta_pkg::COORD_W-1:0]    req_far_y,
   output logic                                   rsp_strobe,
   output logic signed [tpta_pkg::OUT_W-1:0]      rsp_target_x,
   output logic signed [tpta_pkg::OUT_W-1:0]      rsp_target_y,
   output logic signed [tpta_pkg::OUT_W-1:0]      rsp_polar_cosine,
   output logic signed [tpta_pkg::OUT_W-1:0]      rsp_azimuth,
   input  logic                                   csr_we,
   input  tpta_pkg::csr_index_type                csr_index,
   input  logic [tpta_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   // stage count used by the cordic chain, capped at CORDIC_MAX
   localparam int NCS = (CORDIC_STAGES > tpta_pkg::CORDIC_MAX) ?
                        tpta_pkg::CORDIC_MAX : CORDIC_STAGES;
   localparam int CORE    = tpta_pkg::CORE_STAGES;
   localparam int VLD_LEN = CORE + 3;
   localparam int SIDE_W  = 2 * tpta_pkg::COORD_W + 6;
   localparam int XW = tpta_pkg::CX_W;
   localparam int ZW = tpta_pkg::CZ_W;
   localparam int DXN = tpta_pkg::DIVX_NUM_W;
   localparam int DXR = tpta_pkg::DIVX_REM_W;
   localparam int DCN = tpta_pkg::DIVC_NUM_W;
   localparam int DCR = tpta_pkg::DIVC_REM_W;
   localparam int SVW = tpta_pkg::SQRT_VAL_W;
   localparam int SRW = tpta_pkg::SQRT_ROOT_W;

   function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
      logic signed [15:0] r;
      if (v > 36'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -36'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   // ---------------------------------------------------------------- control
   logic                 busy_ff;
   logic                 in_xfer;
   logic [VLD_LEN-1:0]   vld_ff;
   logic                 rsp_strobe_ff;

   logic [tpta_pkg::SPACING_W-1:0] spacing_ff;
   logic [tpta_pkg::GAP_W-1:0]     gap_ff;

   assign in_xfer = start & ~busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b1;
         vld_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
         spacing_ff    <= tpta_pkg::SPACING_RST;
         gap_ff        <= tpta_pkg::GAP_RST;
      end else begin
         busy_ff       <= 1'b0;
         vld_ff        <= {vld_ff[VLD_LEN-2:0], in_xfer};
         rsp_strobe_ff <= vld_ff[VLD_LEN-1];
         if (csr_we) begin
            unique case (csr_index)
               tpta_pkg::REG_PLANE_SPACING: spacing_ff <= csr_wdata;
               tpta_pkg::REG_CATHODE_GAP:   gap_ff     <= csr_wdata[tpta_pkg::GAP_W-1:0];
            endcase
         end
      end
   end

   // ------------------------------------------------ stage 1: differences
   logic signed [15:0] dx_w, dy_w;
   logic signed [17:0] n_w, cxs_w;
   logic signed [16:0] wx_w, wy_w;

   logic signed [14:0] s1_nx_ff, s1_ny_ff;
   logic signed [15:0] s1_dx_ff, s1_dy_ff;
   logic signed [17:0] s1_n_ff, s1_cxs_ff;
   logic signed [16:0] s1_wx_ff, s1_wy_ff;
   logic [14:0]        s1_s_ff;

   always_comb begin
      dx_w  = $signed({req_far_x[14], req_far_x}) - $signed({req_near_x[14], req_near_x});
      dy_w  = $signed({req_far_y[14], req_far_y}) - $signed({req_near_y[14], req_near_y});
      // cosine numerator spacing - dx, azimuth x term dx + spacing
      n_w   = $signed({3'b000, spacing_ff}) - $signed({{2{dx_w[15]}}, dx_w});
      cxs_w = $signed({3'b000, spacing_ff}) + $signed({{2{dx_w[15]}}, dx_w});
      // interpolation weights spacing +/- twice the gap
      wx_w  = $signed({2'b00, spacing_ff}) + $signed({4'b0000, gap_ff, 1'b0});
      wy_w  = $signed({2'b00, spacing_ff}) - $signed({4'b0000, gap_ff, 1'b0});
   end

   always_ff @(posedge clock) begin
      s1_nx_ff  <= req_near_x;
      s1_ny_ff  <= req_near_y;
      s1_dx_ff  <= dx_w;
      s1_dy_ff  <= dy_w;
      s1_n_ff   <= n_w;
      s1_cxs_ff <= cxs_w;
      s1_wx_ff  <= wx_w;
      s1_wy_ff  <= wy_w;
      s1_s_ff   <= spacing_ff;
   end

   // ------------------------------------------------ stage 2: products
   logic signed [32:0] numx_w, numy_w, cy_w;
   logic signed [31:0] dxsq_w, dysq_w;
   logic signed [35:0] nsq_w;
   logic [29:0]        ssq_w;

   logic signed [32:0] s2_numx_ff, s2_numy_ff, s2_cy_ff;
   logic [30:0]        s2_dxsq_ff, s2_dysq_ff;
   logic [29:0]        s2_ssq_ff;
   logic [31:0]        s2_nsq_ff;
   logic signed [17:0] s2_cxs_ff;
   logic               s2_nneg_ff;
   logic signed [14:0] s2_nx_ff, s2_ny_ff;
   logic [14:0]        s2_s_ff;

   always_comb begin
      numx_w = s1_dx_ff * s1_wx_ff;
      numy_w = s1_dy_ff * s1_wy_ff;
      dxsq_w = s1_dx_ff * s1_dx_ff;
      dysq_w = s1_dy_ff * s1_dy_ff;
      ssq_w  = s1_s_ff * s1_s_ff;
      nsq_w  = s1_n_ff * s1_n_ff;
      cy_w   = s1_dy_ff * tpta_pkg::Y_SCALE;
   end

   always_ff @(posedge clock) begin
      s2_numx_ff <= numx_w;
      s2_numy_ff <= numy_w;
      s2_cy_ff   <= cy_w;
      s2_dxsq_ff <= dxsq_w[30:0];
      s2_dysq_ff <= dysq_w[30:0];
      s2_ssq_ff  <= ssq_w;
      s2_nsq_ff  <= nsq_w[31:0];
      s2_cxs_ff  <= s1_cxs_ff;
      s2_nneg_ff <= s1_n_ff[17];
      s2_nx_ff   <= s1_nx_ff;
      s2_ny_ff   <= s1_ny_ff;
      s2_s_ff    <= s1_s_ff;
   end

   // ------------------------------------------------ stage 3: chain setup
   logic [32:0]          magx_w, magy_w;
   logic [31:0]          sqsum_w;
   logic signed [XW-1:0] px_w, py_w, cx0_w, cy0_w;
   logic signed [ZW-1:0] cz0_w;
   logic [SIDE_W-1:0]    side_w;

   logic [DXN-1:0]       s3_numx_ff, s3_numy_ff;
   logic [DXR-1:0]       s3_divs_ff;
   logic [DCR-1:0]       s3_crem_ff, s3_m_ff;
   logic [DCN-1:0]       s3_cnum_ff;
   logic signed [XW-1:0] s3_cx_ff, s3_cy_ff;
   logic signed [ZW-1:0] s3_cz_ff;
   logic [SIDE_W-1:0]    s3_side_ff;

   always_comb begin
      magx_w  = s2_numx_ff[32] ? 33'(-s2_numx_ff) : s2_numx_ff;
      magy_w  = s2_numy_ff[32] ? 33'(-s2_numy_ff) : s2_numy_ff;
      sqsum_w = {1'b0, s2_dxsq_ff} + {1'b0, s2_dysq_ff} + {2'b00, s2_ssq_ff};
      px_w    = {{2{s2_cxs_ff[17]}}, s2_cxs_ff, 15'd0};
      py_w    = {{2{s2_cy_ff[32]}}, s2_cy_ff};
      // negative x: turn by a quarter into the right half plane
      if (px_w[XW-1]) begin
         if (!py_w[XW-1]) begin
            cx0_w = py_w;
            cy0_w = -px_w;
            cz0_w = tpta_pkg::Z_HALF_PI;
         end else begin
            cx0_w = -py_w;
            cy0_w = px_w;
            cz0_w = -tpta_pkg::Z_HALF_PI;
         end
      end else begin
         cx0_w = px_w;
         cy0_w = py_w;
         cz0_w = '0;
      end
      side_w = {s2_nx_ff, s2_ny_ff,
                s2_numx_ff[32],                        // target x offset sign
                s2_numy_ff[32],                        // target y offset sign
                (s2_s_ff == '0),                       // zero spacing
                s2_nneg_ff,                            // cosine sign
                (sqsum_w == '0),                       // zero length direction
                ((s2_cxs_ff == '0) && (s2_cy_ff == '0))}; // direction along z
   end

   always_ff @(posedge clock) begin
      s3_numx_ff <= magx_w[31:0] + {17'd0, s2_s_ff};
      s3_numy_ff <= magy_w[31:0] + {17'd0, s2_s_ff};
      s3_divs_ff <= {s2_s_ff, 1'b0};
      // cosine quotient starts at bit 30, so half of n^2 is the first remainder
      s3_crem_ff <= {2'b00, s2_nsq_ff[31:1]};
      s3_cnum_ff <= {s2_nsq_ff[0], 30'd0};
      s3_m_ff    <= {sqsum_w, 1'b0};
      s3_cx_ff   <= cx0_w;
      s3_cy_ff   <= cy0_w;
      s3_cz_ff   <= cz0_w;
      s3_side_ff <= side_w;
   end

   // ------------------------------------------------ interpolation dividers
   logic [DXN:0][DXR-1:0] dvx_rem, dvy_rem, dvx_div, dvy_div;
   logic [DXN:0][DXN-1:0] dvx_num, dvy_num, dvx_quo, dvy_quo;

   assign dvx_rem[0] = '0;
   assign dvx_num[0] = s3_numx_ff;
   assign dvx_quo[0] = '0;
   assign dvx_div[0] = s3_divs_ff;
   assign dvy_rem[0] = '0;
   assign dvy_num[0] = s3_numy_ff;
   assign dvy_quo[0] = '0;
   assign dvy_div[0] = s3_divs_ff;

   for (genvar k = 0; k < DXN; k++) begin : g_divx
      tpta_div_cell #(.REM_W(DXR), .NUM_W(DXN)) u_cell_x (
         .clock (clock),
         .rem_i (dvx_rem[k]),   .num_i (dvx_num[k]),
         .quo_i (dvx_quo[k]),   .div_i (dvx_div[k]),
         .rem_o (dvx_rem[k+1]), .num_o (dvx_num[k+1]),
         .quo_o (dvx_quo[k+1]), .div_o (dvx_div[k+1])
      );
      tpta_div_cell #(.REM_W(DXR), .NUM_W(DXN)) u_cell_y (
         .clock (clock),
         .rem_i (dvy_rem[k]),   .num_i (dvy_num[k]),
         .quo_i (dvy_quo[k]),   .div_i (dvy_div[k]),
         .rem_o (dvy_rem[k+1]), .num_o (dvy_num[k+1]),
         .quo_o (dvy_quo[k+1]), .div_o (dvy_div[k+1])
      );
   end

   logic [2*DXN-1:0] qxy_d;

   tpta_delay #(.W(2 * DXN), .DEPTH(tpta_pkg::DIVX_PAD)) u_dly_qxy (
      .clock (clock),
      .d_i   ({dvx_quo[DXN], dvy_quo[DXN]}),
      .q_o   (qxy_d)
   );

   // ------------------------------------------------ cosine divider
   logic [DCN:0][DCR-1:0] dvc_rem, dvc_div;
   logic [DCN:0][DCN-1:0] dvc_num, dvc_quo;

   assign dvc_rem[0] = s3_crem_ff;
   assign dvc_num[0] = s3_cnum_ff;
   assign dvc_quo[0] = '0;
   assign dvc_div[0] = s3_m_ff;

   for (genvar k = 0; k < DCN; k++) begin : g_divc
      tpta_div_cell #(.REM_W(DCR), .NUM_W(DCN)) u_cell (
         .clock (clock),
         .rem_i (dvc_rem[k]),   .num_i (dvc_num[k]),
         .quo_i (dvc_quo[k]),   .div_i (dvc_div[k]),
         .rem_o (dvc_rem[k+1]), .num_o (dvc_num[k+1]),
         .quo_o (dvc_quo[k+1]), .div_o (dvc_div[k+1])
      );
   end

   // ------------------------------------------------ square root chain
   logic [SRW:0][SVW-1:0] sq_val;
   logic [SRW:0][SRW+1:0] sq_rem;
   logic [SRW:0][SRW-1:0] sq_root;

   assign sq_val[0]  = {{(SVW - DCN){1'b0}}, dvc_quo[DCN]};
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;

   for (genvar k = 0; k < SRW; k++) begin : g_sqrt
      tpta_sqrt_cell #(.VAL_W(SVW)) u_cell (
         .clock  (clock),
         .val_i  (sq_val[k]),   .rem_i (sq_rem[k]),   .root_i (sq_root[k]),
         .val_o  (sq_val[k+1]), .rem_o (sq_rem[k+1]), .root_o (sq_root[k+1])
      );
   end

   // ------------------------------------------------ cordic chain
   logic signed [XW-1:0] cd_x [NCS+1];
   logic signed [XW-1:0] cd_y [NCS+1];
   logic signed [ZW-1:0] cd_z [NCS+1];
   logic [ZW-1:0]        z_d;

   assign cd_x[0] = s3_cx_ff;
   assign cd_y[0] = s3_cy_ff;
   assign cd_z[0] = s3_cz_ff;

   for (genvar k = 0; k < NCS; k++) begin : g_cordic
      tpta_cordic_cell #(.IDX(k)) u_cell (
         .clock (clock),
         .x_i   (cd_x[k]),   .y_i (cd_y[k]),   .z_i (cd_z[k]),
         .x_o   (cd_x[k+1]), .y_o (cd_y[k+1]), .z_o (cd_z[k+1])
      );
   end

   tpta_delay #(.W(ZW), .DEPTH(CORE - NCS)) u_dly_z (
      .clock (clock),
      .d_i   (cd_z[NCS]),
      .q_o   (z_d)
   );

   // ------------------------------------------------ side data alignment
   logic [SIDE_W-1:0] side_d;

   tpta_delay #(.W(SIDE_W), .DEPTH(CORE)) u_dly_side (
      .clock (clock),
      .d_i   (s3_side_ff),
      .q_o   (side_d)
   );

   // ------------------------------------------------ output stage
   logic signed [14:0] f_nx, f_ny;
   logic               f_negx, f_negy, f_szero, f_cneg, f_mzero, f_azero;
   logic [DXN-1:0]     f_qx, f_qy;
   logic [SRW-1:0]     f_root;
   logic signed [35:0] offx_w, offy_w, tx_w, ty_w, cos_w, az_w;
   logic signed [ZW:0] zr_w;

   logic signed [15:0] tx_ff, ty_ff, cos_ff, az_ff;

   always_comb begin
      {f_nx, f_ny, f_negx, f_negy, f_szero, f_cneg, f_mzero, f_azero} = side_d;
      {f_qx, f_qy} = qxy_d;
      f_root = sq_root[SRW];

      // rounded interpolation term, zero when the spacing is zero
      offx_w = f_negx ? -$signed({4'b0000, f_qx}) : $signed({4'b0000, f_qx});
      offy_w = f_negy ? -$signed({4'b0000, f_qy}) : $signed({4'b0000, f_qy});
      if (f_szero) begin
         offx_w = '0;
         offy_w = '0;
      end
      tx_w = $signed({{21{f_nx[14]}}, f_nx}) + offx_w;
      ty_w = $signed({{21{f_ny[14]}}, f_ny}) + offy_w;

      // signed root, plus one saturates
      if (f_mzero) begin
         cos_w = '0;
      end else if (f_cneg) begin
         cos_w = -$signed({20'd0, f_root});
      end else begin
         cos_w = $signed({20'd0, f_root});
      end

      // round the angle accumulator to pi/32768
      zr_w = $signed({z_d[ZW-1], z_d}) + $signed((ZW + 1)'(128));
      az_w = f_azero ? 36'sd0 : $signed({{(36 - ZW + 7){zr_w[ZW]}}, zr_w[ZW:8]});
   end

   always_ff @(posedge clock) begin
      tx_ff  <= sat16(tx_w);
      ty_ff  <= sat16(ty_w);
      cos_ff <= sat16(cos_w);
      az_ff  <= sat16(az_w);
   end

   assign busy             = busy_ff;
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_target_x     = tx_ff;
   assign rsp_target_y     = ty_ff;
   assign rsp_polar_cosine = cos_ff;
   assign rsp_azimuth      = az_ff;

   // ------------------------------------------------ assertions
   // root of a valid cosine quotient never goes past one
   `TPTA_ASSERT_NOW(a_root_range, clock, reset,
      vld_ff[VLD_LEN-1] && !f_mzero, f_root <= 16'h8000,
      "cosine root out of range")
   // a zero length direction needs zero spacing
   `TPTA_ASSERT_NOW(a_mzero_szero, clock, reset,
      vld_ff[VLD_LEN-1] && f_mzero, f_szero,
      "zero length direction with nonzero spacing")
   // once out of reset the block takes a pair every cycle
   `TPTA_ASSERT_NEXT(a_never_busy, clock, reset,
      !busy_ff, !busy_ff,
      "busy raised outside reset")

endmodule
